FILE: rtl/core/lip_pkg.sv
// ----------------------------------------------------------------------------
// lip_pkg
// Widths, constants and shared types of the line intersection pipeline.
// ----------------------------------------------------------------------------
package lip_pkg;

    // Input coordinates are signed Q12.4, results signed Q16.16
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_W      = 16;
    localparam int PARAM_W    = 32;

    // Point difference, direction cross product, numerator cross product
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int PRODD_W = 2 * COORD_BITS + 1;
    localparam int CROSS_W = 2 * COORD_BITS + 1;
    localparam int NUM_W   = 2 * COORD_BITS + 2;

    // Dividend is |num| scaled by 2^FRAC_BITS; divisor starts aligned to
    // the top quotient bit
    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int DSH_W = CROSS_W + PARAM_W - 1;

    // One divider cell per quotient bit
    localparam int CELLS = PARAM_W;

    localparam logic [PARAM_W-1:0] PARAM_MAX = {1'b0, {(PARAM_W-1){1'b1}}};
    localparam logic [PARAM_W-1:0] PARAM_MIN = {1'b1, {(PARAM_W-1){1'b0}}};

    // Per-request flags that ride along the divider chain
    typedef struct packed {
        logic found;
        logic neg_t;
        logic neg_s;
        logic ovf_t;
        logic ovf_s;
    } t_lip_tag;

    // Divider working set for both quotients
    typedef struct packed {
        logic [DVD_W-1:0]   rem_t;
        logic [DVD_W-1:0]   rem_s;
        logic [PARAM_W-1:0] q_t;
        logic [PARAM_W-1:0] q_s;
        logic [DSH_W-1:0]   dsh;
    } t_lip_work;

    // Finished result
    typedef struct packed {
        logic               found;
        logic [PARAM_W-1:0] first_param;
        logic [PARAM_W-1:0] second_param;
        logic               saturated;
    } t_lip_res;

endpackage

FILE: rtl/core/line_intersection_params.sv
// ----------------------------------------------------------------------------
// line_intersection_params
// Parametric intersection of two lines given as point plus direction.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_ready     eight Q12.4 coordinates
//   out       output     o_out_valid / i_out_ready   found, two Q16.16, saturated
//   cfg       input      i_cfg_valid / o_cfg_ready   min_cross (16 bits)
//
// One request enters per cycle while o_in_ready is high; its result passes
// through five front-end stages (the first loads on the accepting edge),
// a row of 32 divider cells (one quotient bit each) and one output register.
// A skid register behind the output keeps o_in_ready a registered signal;
// it drops at the edge where an output stall fills the skid register.
// Reset empties the pipeline and sets min_cross to 1.
// ----------------------------------------------------------------------------
module line_intersection_params
    import lip_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_first_x,
    input  logic signed [COORD_BITS-1:0]  i_first_y,
    input  logic signed [COORD_BITS-1:0]  i_first_dir_x,
    input  logic signed [COORD_BITS-1:0]  i_first_dir_y,
    input  logic signed [COORD_BITS-1:0]  i_second_x,
    input  logic signed [COORD_BITS-1:0]  i_second_y,
    input  logic signed [COORD_BITS-1:0]  i_second_dir_x,
    input  logic signed [COORD_BITS-1:0]  i_second_dir_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic signed [PARAM_W-1:0]     o_first_param,
    output logic signed [PARAM_W-1:0]     o_second_param,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    logic [CFG_W-1:0] r_min_cross;
    logic             en;

    logic      vld  [CELLS+1];
    t_lip_tag  tag  [CELLS+1];
    t_lip_work work [CELLS+1];

    // Threshold register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cross <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_min_cross <= i_cfg_data;
        end
    end

    assign o_in_ready = en;

    lip_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_first_dir_x  (i_first_dir_x),
        .i_first_dir_y  (i_first_dir_y),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_second_dir_x (i_second_dir_x),
        .i_second_dir_y (i_second_dir_y),
        .i_min_cross    (r_min_cross),
        .o_valid        (vld[0]),
        .o_tag          (tag[0]),
        .o_work         (work[0])
    );

    // Divider row, one quotient bit per cell, most significant first
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        lip_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[g]),
            .i_tag   (tag[g]),
            .i_work  (work[g]),
            .o_valid (vld[g+1]),
            .o_tag   (tag[g+1]),
            .o_work  (work[g+1])
        );
    end

    lip_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (vld[CELLS]),
        .i_tag          (tag[CELLS]),
        .i_work         (work[CELLS]),
        .i_ready        (i_out_ready),
        .o_en           (en),
        .o_valid        (o_out_valid),
        .o_found        (o_found),
        .o_first_param  (o_first_param),
        .o_second_param (o_second_param),
        .o_saturated    (o_saturated)
    );

endmodule

FILE: rtl/core/lip_front.sv
// ----------------------------------------------------------------------------
// lip_front
// Five-stage front end: differences, products, cross products, magnitudes,
// parallel test, overflow precheck and divider setup.
// ----------------------------------------------------------------------------
module lip_front
    import lip_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_BITS-1:0]  i_first_x,
    input  logic signed [COORD_BITS-1:0]  i_first_y,
    input  logic signed [COORD_BITS-1:0]  i_first_dir_x,
    input  logic signed [COORD_BITS-1:0]  i_first_dir_y,
    input  logic signed [COORD_BITS-1:0]  i_second_x,
    input  logic signed [COORD_BITS-1:0]  i_second_y,
    input  logic signed [COORD_BITS-1:0]  i_second_dir_x,
    input  logic signed [COORD_BITS-1:0]  i_second_dir_y,
    input  logic [CFG_W-1:0]              i_min_cross,
    output logic                          o_valid,
    output t_lip_tag                      o_tag,
    output t_lip_work                     o_work
);

    logic [4:0] r_vld;

    // Stage 1 registers
    logic signed [COORD_BITS-1:0] r_adx, r_ady, r_bdx, r_bdy;
    logic signed [DIFF_W-1:0]     r_dx, r_dy;
    // Stage 2 registers
    logic signed [PROD_W-1:0]     r_pc1, r_pc2;
    logic signed [PRODD_W-1:0]    r_pt1, r_pt2, r_ps1, r_ps2;
    // Stage 3 registers
    logic signed [CROSS_W-1:0]    r_c;
    logic signed [NUM_W-1:0]      r_nt, r_ns;
    // Stage 4 registers
    logic [CROSS_W-1:0]           r_mc;
    logic [NUM_W-1:0]             r_mt, r_ms;
    logic                         r_neg_t, r_neg_s;
    // Stage 5 registers
    t_lip_tag                     r_tag;
    t_lip_work                    r_work;

    logic signed [DIFF_W-1:0]     n_dx, n_dy;
    logic signed [PROD_W-1:0]     n_pc1, n_pc2;
    logic signed [PRODD_W-1:0]    n_pt1, n_pt2, n_ps1, n_ps2;
    logic signed [CROSS_W-1:0]    n_c;
    logic signed [NUM_W-1:0]      n_nt, n_ns;
    logic [CROSS_W-1:0]           n_mc;
    logic [NUM_W-1:0]             n_mt, n_ms;
    logic [DVD_W-1:0]             n_rem_t, n_rem_s;
    logic [CROSS_W+PARAM_W-1:0]   n_dtop;
    t_lip_tag                     n_tag;
    t_lip_work                    n_work;

    // Point difference, second minus first
    assign n_dx = $signed({i_second_x[COORD_BITS-1], i_second_x})
                - $signed({i_first_x[COORD_BITS-1], i_first_x});
    assign n_dy = $signed({i_second_y[COORD_BITS-1], i_second_y})
                - $signed({i_first_y[COORD_BITS-1], i_first_y});

    // Six independent products
    assign n_pc1 = r_adx * r_bdy;
    assign n_pc2 = r_ady * r_bdx;
    assign n_pt1 = r_dx * r_bdy;
    assign n_pt2 = r_dy * r_bdx;
    assign n_ps1 = r_dx * r_ady;
    assign n_ps2 = r_dy * r_adx;

    // Cross products
    assign n_c  = $signed({r_pc1[PROD_W-1], r_pc1}) - $signed({r_pc2[PROD_W-1], r_pc2});
    assign n_nt = $signed({r_pt1[PRODD_W-1], r_pt1}) - $signed({r_pt2[PRODD_W-1], r_pt2});
    assign n_ns = $signed({r_ps1[PRODD_W-1], r_ps1}) - $signed({r_ps2[PRODD_W-1], r_ps2});

    // Magnitudes
    assign n_mc = r_c[CROSS_W-1] ? $unsigned(-r_c) : $unsigned(r_c);
    assign n_mt = r_nt[NUM_W-1] ? $unsigned(-r_nt) : $unsigned(r_nt);
    assign n_ms = r_ns[NUM_W-1] ? $unsigned(-r_ns) : $unsigned(r_ns);

    // Parallel test, overflow precheck, divider setup
    assign n_rem_t = {r_mt, {FRAC_BITS{1'b0}}};
    assign n_rem_s = {r_ms, {FRAC_BITS{1'b0}}};
    assign n_dtop  = {r_mc, {PARAM_W{1'b0}}};

    always_comb begin
        n_tag.found = (r_mc != '0) && (r_mc >= {{(CROSS_W-CFG_W){1'b0}}, i_min_cross});
        n_tag.neg_t = r_neg_t;
        n_tag.neg_s = r_neg_s;
        n_tag.ovf_t = {{(CROSS_W+PARAM_W-DVD_W){1'b0}}, n_rem_t} >= n_dtop;
        n_tag.ovf_s = {{(CROSS_W+PARAM_W-DVD_W){1'b0}}, n_rem_s} >= n_dtop;
        n_work.rem_t = n_rem_t;
        n_work.rem_s = n_rem_s;
        n_work.q_t   = '0;
        n_work.q_s   = '0;
        n_work.dsh   = {r_mc, {(PARAM_W-1){1'b0}}};
    end

    // Advance stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Advance stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_adx   <= i_first_dir_x;
            r_ady   <= i_first_dir_y;
            r_bdx   <= i_second_dir_x;
            r_bdy   <= i_second_dir_y;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_pc1   <= n_pc1;
            r_pc2   <= n_pc2;
            r_pt1   <= n_pt1;
            r_pt2   <= n_pt2;
            r_ps1   <= n_ps1;
            r_ps2   <= n_ps2;
            r_c     <= n_c;
            r_nt    <= n_nt;
            r_ns    <= n_ns;
            r_mc    <= n_mc;
            r_mt    <= n_mt;
            r_ms    <= n_ms;
            r_neg_t <= r_nt[NUM_W-1] ^ r_c[CROSS_W-1];
            r_neg_s <= r_ns[NUM_W-1] ^ r_c[CROSS_W-1];
            r_tag   <= n_tag;
            r_work  <= n_work;
        end
    end

    assign o_valid = r_vld[4];
    assign o_tag   = r_tag;
    assign o_work  = r_work;

endmodule

FILE: rtl/core/lip_cell.sv
// ----------------------------------------------------------------------------
// lip_cell
// One restoring divide step for both quotients; hands its result to the
// next cell every enabled cycle.
// ----------------------------------------------------------------------------
module lip_cell
    import lip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_lip_tag  i_tag,
    input  t_lip_work i_work,
    output logic      o_valid,
    output t_lip_tag  o_tag,
    output t_lip_work o_work
);

    logic      r_valid;
    t_lip_tag  r_tag;
    t_lip_work r_work;
    t_lip_work n_work;
    logic      ge_t, ge_s;

    // Compare remainders against the aligned divisor
    assign ge_t = {{(DSH_W-DVD_W){1'b0}}, i_work.rem_t} >= i_work.dsh;
    assign ge_s = {{(DSH_W-DVD_W){1'b0}}, i_work.rem_s} >= i_work.dsh;

    // Subtract where it fits, shift in the quotient bit, step the divisor down
    always_comb begin
        n_work.rem_t = ge_t ? (i_work.rem_t - i_work.dsh[DVD_W-1:0]) : i_work.rem_t;
        n_work.rem_s = ge_s ? (i_work.rem_s - i_work.dsh[DVD_W-1:0]) : i_work.rem_s;
        n_work.q_t   = {i_work.q_t[PARAM_W-2:0], ge_t};
        n_work.q_s   = {i_work.q_s[PARAM_W-2:0], ge_s};
        n_work.dsh   = {1'b0, i_work.dsh[DSH_W-1:1]};
    end

    // Hold valid across stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag  <= i_tag;
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_work  = r_work;

endmodule

FILE: rtl/core/lip_out.sv
// ----------------------------------------------------------------------------
// lip_out
// Sign restore and saturation of both quotients, output register and skid
// register; produces the pipeline advance enable.
// ----------------------------------------------------------------------------
module lip_out
    import lip_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_lip_tag                   i_tag,
    input  t_lip_work                  i_work,
    input  logic                       i_ready,
    output logic                       o_en,
    output logic                       o_valid,
    output logic                       o_found,
    output logic signed [PARAM_W-1:0]  o_first_param,
    output logic signed [PARAM_W-1:0]  o_second_param,
    output logic                       o_saturated
);

    logic     r_out_valid, r_skid_valid;
    t_lip_res r_out, r_skid;
    t_lip_res n_res;
    logic [PARAM_W:0] fix_t, fix_s;
    logic     take;

    // Returns {saturated, value} for one quotient magnitude
    function automatic logic [PARAM_W:0] lip_fix(
        input logic               neg,
        input logic               ovf,
        input logic [PARAM_W-1:0] q
    );
        logic               s;
        logic [PARAM_W-1:0] v;
        if (ovf) begin
            s = 1'b1;
            v = neg ? PARAM_MIN : PARAM_MAX;
        end else if (!neg) begin
            s = q[PARAM_W-1];
            v = s ? PARAM_MAX : q;
        end else begin
            s = q > PARAM_MIN;
            v = s ? PARAM_MIN : (PARAM_W'(0) - q);
        end
        return {s, v};
    endfunction

    // Finish the result; parallel lines give all zeros
    assign fix_t = lip_fix(i_tag.neg_t, i_tag.ovf_t, i_work.q_t);
    assign fix_s = lip_fix(i_tag.neg_s, i_tag.ovf_s, i_work.q_s);

    always_comb begin
        n_res.found        = i_tag.found;
        n_res.first_param  = i_tag.found ? fix_t[PARAM_W-1:0] : '0;
        n_res.second_param = i_tag.found ? fix_s[PARAM_W-1:0] : '0;
        n_res.saturated    = i_tag.found & (fix_t[PARAM_W] | fix_s[PARAM_W]);
    end

    assign take = r_out_valid & i_ready;
    assign o_en = !r_skid_valid;

    // Output and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (r_out_valid && !take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_out.found;
    assign o_first_param  = $signed(r_out.first_param);
    assign o_second_param = $signed(r_out.second_param);
    assign o_saturated    = r_out.saturated;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_ready |=> r_skid_valid)
        else $error("skid request dropped while output stalled");

    a_sat_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_found)
        else $error("saturation flagged on parallel lines");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_first_param == '0) && (o_second_param == '0))
        else $error("nonzero parameters on parallel lines");
`endif

endmodule
